// ===== rtl/core/ilid_pkg.sv =====
package ilid_pkg;

  localparam int CAPACITY = 1024;
  localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int POS_W    = 16;
  localparam int CMP_W    = (CNT_W > POS_W) ? CNT_W : POS_W;
  localparam int DATA_W   = 32;
  localparam int COUNT_W  = 11;
  localparam int GROUP    = 32;
  localparam int NGROUP   = (CAPACITY + GROUP - 1) / GROUP;

  typedef enum logic [2:0] {
    MODE_GET     = 3'd0,
    MODE_INS_HD  = 3'd1,
    MODE_INS_TL  = 3'd2,
    MODE_INS_IDX = 3'd3,
    MODE_DEL     = 3'd4
  } mode_e;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE = 2'd0,
    S_RD1  = 2'd1,
    S_RD2  = 2'd2
  } state_e;

  // broadcast to every cell of the row
  typedef struct packed {
    logic              ins;
    logic              del;
    logic [IDX_W-1:0]  idx;
    logic [DATA_W-1:0] value;
  } cell_cmd_t;

endpackage

// ===== rtl/core/ilid_cell.sv =====
module ilid_cell (
  input  logic                       clk_i,
  input  logic [ilid_pkg::IDX_W-1:0] idx_i,
  input  ilid_pkg::cell_cmd_t        cmd_i,
  input  logic [ilid_pkg::DATA_W-1:0] left_i,
  input  logic [ilid_pkg::DATA_W-1:0] right_i,
  input  logic [ilid_pkg::IDX_W-1:0] rd_idx_i,
  output logic [ilid_pkg::DATA_W-1:0] data_o,
  output logic [ilid_pkg::DATA_W-1:0] rd_o
);
  import ilid_pkg::*;

  logic [DATA_W-1:0] data_q, data_d;

  always_comb begin
    data_d = data_q;
    if (cmd_i.ins) begin
      if (idx_i > cmd_i.idx) begin
        data_d = left_i;
      end else if (idx_i == cmd_i.idx) begin
        data_d = cmd_i.value;
      end
    end else if (cmd_i.del) begin
      if (idx_i >= cmd_i.idx) begin
        data_d = right_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;
  // only the addressed cell drives the read tree
  assign rd_o   = (idx_i == rd_idx_i) ? data_q : '0;

endmodule

// ===== rtl/core/ilid_read_tree.sv =====
module ilid_read_tree (
  input  logic                                         clk_i,
  input  logic [ilid_pkg::CAPACITY-1:0][ilid_pkg::DATA_W-1:0] leaf_i,
  output logic [ilid_pkg::DATA_W-1:0]                  value_o
);
  import ilid_pkg::*;

  logic [NGROUP*GROUP-1:0][DATA_W-1:0] leaf_pad;
  logic [NGROUP-1:0][DATA_W-1:0]       grp_d;
  logic [NGROUP-1:0][DATA_W-1:0]       grp_q;

  always_comb begin
    leaf_pad = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      leaf_pad[i] = leaf_i[i];
    end
  end

  always_comb begin
    for (int g = 0; g < NGROUP; g++) begin
      grp_d[g] = '0;
      for (int k = 0; k < GROUP; k++) begin
        grp_d[g] = grp_d[g] | leaf_pad[g*GROUP + k];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    grp_q <= grp_d;
  end

  always_comb begin
    value_o = '0;
    for (int g = 0; g < NGROUP; g++) begin
      value_o = value_o | grp_q[g];
    end
  end

endmodule

// ===== rtl/core/indexed_list_insert_delete.sv =====
// indexed sequence store: get, insert and delete by position
//
// command channel: a word is taken at the rising edge where start_i is high
// and busy_o is low; mode_i, position_i and item_value_i are sampled there.
// result channel: every command gives one word on read_value_o, status_o
// and count_o, shown for exactly one cycle while done_o is high. the
// receiver cannot stall, so results are never held back.
//
// the entries live in a row of cells; an insert moves cells at and above the
// position up by one, a delete moves those above it down, both at accept.
// insert, delete, rejected commands: result in the cycle after accept, one
// command per cycle.
// valid get: the read address is registered, the addressed cell feeds a
// two-level or-tree (groups of 32 cells) with a registered group level, and
// the result is registered; busy_o stays high in S_RD1 and S_RD2 meanwhile.
//
// reset clears the length and the control state; cell contents are not
// cleared, only positions below the length are ever read.
module indexed_list_insert_delete (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  output logic                          busy_o,
  input  logic [2:0]                    mode_i,
  input  logic signed [15:0]            position_i,
  input  logic signed [31:0]            item_value_i,
  output logic                          done_o,
  output logic signed [31:0]            read_value_o,
  output logic [1:0]                    status_o,
  output logic [ilid_pkg::COUNT_W-1:0]  count_o
);
  import ilid_pkg::*;

  state_e             state_q, state_d;
  logic [CNT_W-1:0]   len_q, len_d;
  logic [IDX_W-1:0]   rd_idx_q, rd_idx_d;
  logic               done_q, done_d;
  logic [DATA_W-1:0]  rv_q, rv_d;
  status_e            st_q, st_d;
  logic [COUNT_W-1:0] cnt_q;

  cell_cmd_t          cmd;
  logic               accept;
  logic               go_read;
  logic [CMP_W-1:0]   pos_ext, len_ext, ins_ext;
  logic               get_ok;
  logic               full;
  logic [DATA_W-1:0]  tree_value;

  logic [CAPACITY-1:0][DATA_W-1:0] cell_data;
  logic [CAPACITY-1:0][DATA_W-1:0] cell_rd;

  assign accept  = start_i && (state_q == S_IDLE);
  assign pos_ext = CMP_W'($unsigned(position_i[POS_W-2:0]));
  assign len_ext = CMP_W'(len_q);
  assign get_ok  = !position_i[POS_W-1] && (pos_ext < len_ext);
  assign ins_ext = position_i[POS_W-1] ? '0 : pos_ext;
  assign full    = (len_q >= CNT_W'(CAPACITY));

  // command decode, length update and result words
  always_comb begin
    cmd      = '0;
    cmd.value = item_value_i;
    len_d    = len_q;
    rd_idx_d = rd_idx_q;
    done_d   = 1'b0;
    rv_d     = '1;
    st_d     = ST_DONE;
    go_read  = 1'b0;
    if (state_q == S_RD2) begin
      done_d = 1'b1;
      rv_d   = tree_value;
    end else if (accept) begin
      done_d = 1'b1;
      case (mode_i)
        MODE_GET: begin
          if (get_ok) begin
            done_d   = 1'b0;
            go_read  = 1'b1;
            rd_idx_d = IDX_W'(pos_ext);
          end else begin
            st_d = ST_RANGE;
          end
        end
        MODE_INS_HD, MODE_INS_TL: begin
          if (full) begin
            st_d = ST_FULL;
          end else begin
            cmd.ins = 1'b1;
            cmd.idx = (mode_i == MODE_INS_HD) ? '0 : IDX_W'(len_q);
            len_d   = len_q + 1'b1;
          end
        end
        MODE_INS_IDX: begin
          if (ins_ext > len_ext) begin
            st_d = ST_RANGE;
          end else if (full) begin
            st_d = ST_FULL;
          end else begin
            cmd.ins = 1'b1;
            cmd.idx = IDX_W'(ins_ext);
            len_d   = len_q + 1'b1;
          end
        end
        MODE_DEL: begin
          if (get_ok) begin
            cmd.del = 1'b1;
            cmd.idx = IDX_W'(pos_ext);
            len_d   = len_q - 1'b1;
          end else begin
            st_d = ST_RANGE;
          end
        end
        default: begin
          st_d = ST_RANGE;
        end
      endcase
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:  if (go_read) state_d = S_RD1;
      S_RD1:   state_d = S_RD2;
      S_RD2:   state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      len_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      len_q   <= len_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_idx_q <= rd_idx_d;
    if (done_d) begin
      rv_q  <= rv_d;
      st_q  <= st_d;
      cnt_q <= COUNT_W'(len_d);
    end
  end

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [DATA_W-1:0] left_w, right_w;
    if (i == 0) begin : g_first
      assign left_w = '0;
    end else begin : g_mid_l
      assign left_w = cell_data[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign right_w = cell_data[i];
    end else begin : g_mid_r
      assign right_w = cell_data[i+1];
    end
    ilid_cell u_cell (
      .clk_i    (clk_i),
      .idx_i    (IDX_W'(i)),
      .cmd_i    (cmd),
      .left_i   (left_w),
      .right_i  (right_w),
      .rd_idx_i (rd_idx_q),
      .data_o   (cell_data[i]),
      .rd_o     (cell_rd[i])
    );
  end

  ilid_read_tree u_read_tree (
    .clk_i   (clk_i),
    .leaf_i  (cell_rd),
    .value_o (tree_value)
  );

  assign busy_o       = (state_q != S_IDLE);
  assign done_o       = done_q;
  assign read_value_o = $signed(rv_q);
  assign status_o     = st_q;
  assign count_o      = cnt_q;

  a_len_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    len_q <= CNT_W'(CAPACITY))
    else $error("length above capacity");

  a_get_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && (mode_i == MODE_GET) && get_ok) |-> ##3 done_o && (status_o == ST_DONE))
    else $error("valid get did not answer on time");

  a_no_done_mid_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_RD1) |-> !done_o)
    else $error("result while read tree is filling");

  a_full_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && (status_o == ST_FULL)) |-> (count_o == COUNT_W'(CAPACITY)))
    else $error("full status with store not full");

endmodule

// ===== tb/ilid_list_monitor.sv =====
module ilid_list_monitor
  import ilid_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic                busy_o,
  input  logic [2:0]          mode_i,
  input  logic signed [15:0]  position_i,
  input  logic signed [31:0]  item_value_i,
  input  logic                done_o,
  input  logic signed [31:0]  read_value_o,
  input  logic [1:0]          status_o,
  input  logic [COUNT_W-1:0]  count_o,
  output int                  errors_o,
  output int                  pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [DATA_W-1:0]  read_value;
    logic [1:0]         status;
    logic [COUNT_W-1:0] count;
  } list_reply_t;

  logic [DATA_W-1:0] shadow_mem [CAPACITY];
  int                shadow_len;
  list_reply_t       reply_queue [$];

  initial errors_o = 0;

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    errors_o++;
    if (errors_o <= 100)
      $display("mismatch, %s: got %0h want %0h at %0t ns", what, got, want, $realtime);
  endtask

  // updates the shadow sequence and returns the word the block should answer
  function automatic list_reply_t apply_list_request(input logic [2:0] mode,
                                                     input logic signed [15:0] pos,
                                                     input logic [DATA_W-1:0] value);
    list_reply_t r;
    int          slot;
    logic        do_insert;
    r.read_value = '1;
    r.status     = ST_DONE;
    do_insert    = 1'b0;
    slot         = 0;
    case (mode)
      MODE_GET: begin
        if (pos >= 0 && pos < shadow_len) r.read_value = shadow_mem[pos];
        else r.status = ST_RANGE;
      end
      MODE_INS_HD, MODE_INS_TL: begin
        slot = (mode == MODE_INS_HD) ? 0 : shadow_len;
        if (shadow_len >= CAPACITY) r.status = ST_FULL;
        else do_insert = 1'b1;
      end
      MODE_INS_IDX: begin
        // negative positions clamp to the head; range wins over full
        slot = (pos < 0) ? 0 : int'(pos);
        if (slot > shadow_len) r.status = ST_RANGE;
        else if (shadow_len >= CAPACITY) r.status = ST_FULL;
        else do_insert = 1'b1;
      end
      MODE_DEL: begin
        if (pos >= 0 && pos < shadow_len) begin
          for (int i = int'(pos); i < shadow_len - 1; i++) shadow_mem[i] = shadow_mem[i+1];
          shadow_len--;
        end else begin
          r.status = ST_RANGE;
        end
      end
      default: r.status = ST_RANGE;
    endcase
    if (do_insert) begin
      for (int i = shadow_len; i > slot; i--) shadow_mem[i] = shadow_mem[i-1];
      shadow_mem[slot] = value;
      shadow_len++;
    end
    r.count = shadow_len[COUNT_W-1:0];
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    list_reply_t want;
    if (!rst_ni) begin
      shadow_len = 0;
      reply_queue.delete();
      pending_o = 0;
    end else begin
      // a word out at this edge always belongs to an earlier command
      if (done_o) begin
        if (reply_queue.size() == 0) begin
          report_mismatch("word with none expected", read_value_o, '1);
        end else begin
          want = reply_queue.pop_front();
          if (read_value_o !== want.read_value)
            report_mismatch("read_value", read_value_o, want.read_value);
          if (status_o !== want.status)
            report_mismatch("status", 32'(status_o), 32'(want.status));
          if (count_o !== want.count)
            report_mismatch("count", 32'(count_o), 32'(want.count));
        end
      end
      if (start_i && !busy_o)
        reply_queue.push_back(apply_list_request(mode_i, position_i, item_value_i));
      pending_o = reply_queue.size();
    end
  end

endmodule

// ===== tb/tb_indexed_list_insert_delete.sv =====
module tb_indexed_list_insert_delete;
  import ilid_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [2:0] MODE_FIRST_SPARE = 3'd5;
  localparam int         RAND_ITEMS       = 1925;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                start_i = 1'b0;
  logic                busy_o;
  logic [2:0]          mode_i = MODE_GET;
  logic signed [15:0]  position_i = '0;
  logic signed [31:0]  item_value_i = '0;
  logic                done_o;
  logic signed [31:0]  read_value_o;
  logic [1:0]          status_o;
  logic [COUNT_W-1:0]  count_o;
  int                  errors;
  int                  pending;

  int   fill_level = 0;
  int   burst_left = 0;
  int   words_sent = 0;
  logic driving = 1'b0;

  always #2 clk_i = ~clk_i;

  indexed_list_insert_delete i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start_i),
    .busy_o       (busy_o),
    .mode_i       (mode_i),
    .position_i   (position_i),
    .item_value_i (item_value_i),
    .done_o       (done_o),
    .read_value_o (read_value_o),
    .status_o     (status_o),
    .count_o      (count_o)
  );

  ilid_list_monitor i_monitor (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start_i),
    .busy_o       (busy_o),
    .mode_i       (mode_i),
    .position_i   (position_i),
    .item_value_i (item_value_i),
    .done_o       (done_o),
    .read_value_o (read_value_o),
    .status_o     (status_o),
    .count_o      (count_o),
    .errors_o     (errors),
    .pending_o    (pending)
  );

  // steer positions from the length the block last reported
  always @(posedge clk_i) begin
    if (done_o) fill_level <= int'(count_o);
  end

  // called at a falling edge; returns at a falling edge after the handshake
  task automatic issue_word(input logic [2:0] mode, input logic signed [15:0] pos,
                            input logic signed [31:0] value);
    start_i      <= 1'b1;
    driving      = 1'b1;
    mode_i       <= mode;
    position_i   <= pos;
    item_value_i <= value;
    do @(posedge clk_i); while (busy_o);
    @(negedge clk_i);
    words_sent++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      start_i <= 1'b0;
      driving = 1'b0;
      repeat ($urandom_range(1, 8)) @(negedge clk_i);
      burst_left = ($urandom_range(0, 1) != 0) ? $urandom_range(1, 6) : $urandom_range(20, 200);
    end
  endtask

  task automatic wait_drained();
    if (driving) begin
      start_i <= 1'b0;
      driving = 1'b0;
    end
    while (pending != 0) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic random_word(input int ins_pct, input int del_pct);
    int                 pick;
    int                 sel;
    logic [2:0]         mode;
    logic signed [15:0] pos;
    logic signed [31:0] value;
    pick = $urandom_range(0, 99);
    sel  = $urandom_range(0, 9);
    if (pick < ins_pct) begin
      case ($urandom_range(0, 2))
        0:       mode = MODE_INS_HD;
        1:       mode = MODE_INS_TL;
        default: mode = MODE_INS_IDX;
      endcase
    end else if (pick < ins_pct + del_pct) begin
      mode = MODE_DEL;
    end else if (pick < ins_pct + del_pct + 3) begin
      mode = MODE_FIRST_SPARE + 3'($urandom_range(0, 2));
    end else begin
      mode = MODE_GET;
    end
    if (sel == 0) pos = 16'($urandom);
    else if (sel == 1) pos = -16'($urandom_range(1, 32768));
    else pos = 16'($urandom_range(0, fill_level));
    case ($urandom_range(0, 7))
      0:       value = 32'h7fff_ffff;
      1:       value = 32'h8000_0000;
      default: value = $urandom;
    endcase
    issue_word(mode, pos, value);
  endtask

  initial begin
    int guard;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    burst_left = 3;

    // empty store
    issue_word(MODE_GET, 16'sd0, 32'sd0);
    issue_word(MODE_GET, -16'sd1, 32'sd0);
    issue_word(MODE_DEL, 16'sd0, 32'sd0);
    issue_word(MODE_INS_IDX, 16'sd1, 32'sd7);
    for (int k = 0; k < 3; k++) issue_word(MODE_FIRST_SPARE + 3'(k), '1, '1);
    // clamped head insert, then head, tail, append at length, middle
    issue_word(MODE_INS_IDX, -16'sd32768, 32'h7fff_ffff);
    issue_word(MODE_INS_HD, 16'sd0, 32'h8000_0000);
    issue_word(MODE_INS_TL, 16'sd0, 32'h0000_0000);
    issue_word(MODE_INS_IDX, 16'sd3, 32'hffff_ffff);
    issue_word(MODE_INS_IDX, 16'sd2, 32'h5555_aaaa);
    issue_word(MODE_GET, 16'sd0, 32'sd0);
    issue_word(MODE_GET, 16'sd4, 32'sd0);
    issue_word(MODE_GET, 16'sd5, 32'sd0);
    issue_word(MODE_GET, 16'sd32767, 32'sd0);
    issue_word(MODE_GET, -16'sd32768, 32'sd0);
    issue_word(MODE_DEL, 16'sd4, 32'sd0);
    issue_word(MODE_DEL, 16'sd0, 32'sd0);
    issue_word(MODE_DEL, 16'sd5, 32'sd0);
    issue_word(MODE_DEL, -16'sd1, 32'sd0);
    issue_word(MODE_INS_IDX, 16'sd32767, 32'sd1);
    wait_drained();

    // fill up to capacity
    guard = 0;
    while (fill_level < CAPACITY && guard < 3000) begin
      random_word(88, 4);
      guard++;
    end
    wait_drained();
    // sit at full: dropped inserts, out-of-range inserts, reads
    repeat (60) random_word(70, 2);
    // drain with the rest of the budget
    while (words_sent < RAND_ITEMS + 25) random_word(10, 75);

    wait_drained();
    repeat (8) @(posedge clk_i);
    if (errors == 0 && pending == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin
    #1_000_000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule
